// ===== sv/button_debounce_press_classifier_top_macros.svh =====
// Assertion macros shared by the debounce and press classifier RTL.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH

// Check a property on every clock edge, masked while reset is asserted.
`define BDPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BDPC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/bdpc_pkg.sv =====
// Types and constants for the button debounce and press classifier.
package bdpc_pkg;

	// Configuration register widths.
	localparam int CFG_W = 16;
	localparam int EN_W  = 3;

	// Configuration port geometry: four registers in 32-bit words at 4*i.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Default counter width.
	localparam int COUNT_WIDTH_DEF = 16;

	// Register indexes.
	localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [1:0] REG_LONG      = 2'd1;
	localparam logic [1:0] REG_VERY_LONG = 2'd2;
	localparam logic [1:0] REG_ENABLE    = 2'd3;

	// Event enable bit positions.
	localparam int EN_SHORT     = 0;
	localparam int EN_LONG      = 1;
	localparam int EN_VERY_LONG = 2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd5;
	localparam logic [CFG_W-1:0] LONG_RST      = 16'd300;
	localparam logic [CFG_W-1:0] VERY_LONG_RST = 16'd1000;
	localparam logic [EN_W-1:0]  ENABLE_RST    = 3'd7;

	// One result item.
	typedef struct packed {
		logic short_press;
		logic long_press;
		logic very_long_press;
		logic pressed_stable;
	} result_t;

endpackage

// ===== sv/bdpc_if.sv =====
// Valid/ready channel interfaces for pin samples and press results.
interface bdpc_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bdpc_out_if;
	logic valid;
	logic ready;
	logic short_press;
	logic long_press;
	logic very_long_press;
	logic pressed_stable;

	modport source (output valid, output short_press, output long_press,
		output very_long_press, output pressed_stable, input ready);
	modport sink (input valid, input short_press, input long_press,
		input very_long_press, input pressed_stable, output ready);
endinterface

// ===== sv/button_debounce_press_classifier_top.sv =====
// Button debounce and short/long/very long press classifier, top level.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------
//  sample   | in  | valid/ready     | pin_level (0 = pressed)
//  result   | out | valid/ready     | short_press, long_press, very_long_press,
//           |     |                 | pressed_stable
//  config   | in  | APB, pready = 1 | 4 x 32-bit words at byte address 4*i
//
// One sample per clock: each transfer updates the counters and flags at its own
// edge and loads its result into the output register, or, when stalled, the skid
// register; a result in the output register can transfer from the next cycle
// on. A two-entry output stage (result register plus skid register) lets a new
// sample be taken while one result waits; sample.ready drops only when both
// entries are full. Reset restores the default thresholds and clears all state.
`include "button_debounce_press_classifier_top_macros.svh"

module button_debounce_press_classifier_top #(
	parameter int COUNT_WIDTH = bdpc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bdpc_in_if.sink                     sample,
	bdpc_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdpc_pkg::ADDR_W-1:0] paddr,
	input  logic [bdpc_pkg::DATA_W-1:0] pwdata,
	output logic [bdpc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import bdpc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// Configuration registers.
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_q;
	logic [CFG_W-1:0] very_long_q;
	logic [EN_W-1:0]  enable_q;

	// Classifier state.
	logic                   raw_prev_q;
	logic                   stable_q;
	logic [COUNT_WIDTH-1:0] settle_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic                   long_fired_q;
	logic                   very_long_fired_q;

	// Output stage.
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	logic                   cfg_wr;
	logic [1:0]             cfg_idx;
	logic                   accept;
	logic                   raw;
	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [COUNT_WIDTH-1:0] settle_n;
	logic [COUNT_WIDTH-1:0] hold_n;
	logic                   raw_prev_n;
	logic                   stable_n;
	logic                   long_fired_n;
	logic                   very_long_fired_n;
	logic                   settled;
	logic [CMP_W-1:0]       settle_x;
	logic [CMP_W-1:0]       hold_x;
	logic [CMP_W-1:0]       deb_x;
	logic [CMP_W-1:0]       long_x;
	logic [CMP_W-1:0]       very_long_x;
	result_t                res;

	// Configuration port: zero wait states, decode by word index.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (cfg_idx)
			REG_DEBOUNCE:  prdata = DATA_W'(debounce_q);
			REG_LONG:      prdata = DATA_W'(long_q);
			REG_VERY_LONG: prdata = DATA_W'(very_long_q);
			REG_ENABLE:    prdata = DATA_W'(enable_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			long_q      <= LONG_RST;
			very_long_q <= VERY_LONG_RST;
			enable_q    <= ENABLE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEBOUNCE:  debounce_q  <= pwdata[CFG_W-1:0];
				REG_LONG:      long_q      <= pwdata[CFG_W-1:0];
				REG_VERY_LONG: very_long_q <= pwdata[CFG_W-1:0];
				REG_ENABLE:    enable_q    <= pwdata[EN_W-1:0];
				default:       ;
			endcase
		end
	end

	// Take a sample whenever the skid entry is free.
	assign sample.ready = ~skid_valid_q;
	assign accept       = sample.valid & sample.ready;

	// Advance the counters for this tick.
	assign raw      = ~sample.pin_level;
	assign hold_inc = (stable_q && hold_q != CNT_MAX) ? hold_q + 1'b1 : hold_q;

	always_comb begin
		if (raw != raw_prev_q) begin
			settle_n   = '0;
			raw_prev_n = raw;
		end else begin
			settle_n   = (settle_q == CNT_MAX) ? settle_q : settle_q + 1'b1;
			raw_prev_n = raw_prev_q;
		end
	end

	assign settle_x    = CMP_W'(settle_n);
	assign hold_x      = CMP_W'(hold_inc);
	assign deb_x       = CMP_W'(debounce_q);
	assign long_x      = CMP_W'(long_q);
	assign very_long_x = CMP_W'(very_long_q);
	assign settled     = settle_x >= deb_x;

	// Classify the settled level against the debounced state.
	always_comb begin
		stable_n          = stable_q;
		hold_n            = hold_inc;
		long_fired_n      = long_fired_q;
		very_long_fired_n = very_long_fired_q;
		res               = '0;
		if (settled) begin
			if (raw && !stable_q) begin
				stable_n          = 1'b1;
				hold_n            = '0;
				long_fired_n      = 1'b0;
				very_long_fired_n = 1'b0;
			end else if (!raw && stable_q) begin
				res.short_press = ~long_fired_q & ~very_long_fired_q &
					(hold_x >= deb_x) & (hold_x < long_x) & enable_q[EN_SHORT];
				stable_n = 1'b0;
			end else if (raw && stable_q) begin
				if (!long_fired_q && hold_x >= long_x) begin
					long_fired_n   = 1'b1;
					res.long_press = enable_q[EN_LONG];
				end
				if (!very_long_fired_q && hold_x >= very_long_x) begin
					very_long_fired_n   = 1'b1;
					res.very_long_press = enable_q[EN_VERY_LONG];
				end
			end
		end
		res.pressed_stable = stable_n;
	end

	// Commit the state on each sample transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_prev_q        <= 1'b0;
			stable_q          <= 1'b0;
			settle_q          <= '0;
			hold_q            <= '0;
			long_fired_q      <= 1'b0;
			very_long_fired_q <= 1'b0;
		end else if (accept) begin
			raw_prev_q        <= raw_prev_n;
			stable_q          <= stable_n;
			settle_q          <= settle_n;
			hold_q            <= hold_n;
			long_fired_q      <= long_fired_n;
			very_long_fired_q <= very_long_fired_n;
		end
	end

	// Output register with skid entry: drain the skid first, park when stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (result.ready) skid_valid_q <= 1'b0;
			end else if (accept && out_valid_q && !result.ready) begin
				skid_valid_q <= 1'b1;
			end
			if (accept || skid_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result.ready) out_q <= skid_q;
		end else if (accept) begin
			if (!out_valid_q || result.ready) out_q <= res;
			else skid_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.short_press     = out_q.short_press;
	assign result.long_press      = out_q.long_press;
	assign result.very_long_press = out_q.very_long_press;
	assign result.pressed_stable  = out_q.pressed_stable;

	// Checks on the output stage and the classifier.
	`BDPC_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
	`BDPC_ASSERT(a_short_released, (out_valid_q && out_q.short_press) |-> !out_q.pressed_stable, "short press while still pressed")
	`BDPC_ASSERT(a_long_held, (out_valid_q && (out_q.long_press || out_q.very_long_press)) |-> out_q.pressed_stable, "long event while released")
	`BDPC_ASSERT(a_hold_restart, $rose(stable_q) |-> (hold_q == '0), "hold count not restarted on press")
	`BDPC_ASSERT(a_no_accept_when_full, (skid_valid_q && !result.ready) |=> skid_valid_q, "skid entry lost while stalled")

endmodule
